/* rtl/sdi_pkg.sv */
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and codes for the SD card identification sequencer: the result
// item carried from the step logic to the output queue, request, error and
// command codes, and the configuration register indexes.
// ----------------------------------------------------------------------------
package sdi_pkg;

  // request codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_RESP    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_PATTERN = 2'd1;
  localparam logic [1:0] REG_TRIALS  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_V1      = 3'd1;
  localparam logic [2:0] ERR_PATTERN = 3'd2;
  localparam logic [2:0] ERR_VOLTAGE = 3'd3;
  localparam logic [2:0] ERR_RCA     = 3'd4;
  localparam logic [2:0] ERR_NORESP  = 3'd5;
  localparam logic [2:0] ERR_CSD     = 3'd6;

  // expected response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_LONG  = 2'd2;

  // SD command indexes
  localparam logic [5:0] SD_CMD0   = 6'd0;
  localparam logic [5:0] SD_CMD2   = 6'd2;
  localparam logic [5:0] SD_CMD3   = 6'd3;
  localparam logic [5:0] SD_ACMD6  = 6'd6;
  localparam logic [5:0] SD_CMD7   = 6'd7;
  localparam logic [5:0] SD_CMD8   = 6'd8;
  localparam logic [5:0] SD_CMD9   = 6'd9;
  localparam logic [5:0] SD_CMD17  = 6'd17;
  localparam logic [5:0] SD_ACMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55  = 6'd55;

  // one result item, as presented on the result channel
  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        done_res;
    logic [2:0]  error_code;
    logic [15:0] card_rca;
    logic [41:0] capacity_bytes;
    logic [15:0] block_size;
    logic [22:0] erase_sector_size;
    logic        bus_wide;
    logic        last;
  } result_t;

  // what the step logic hands to the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;     // number of items pushed (0, 1 or 2)
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* rtl/sd_card_init_sequencer.sv */
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// Host-side SD identification sequencer: turns start, response, timeout and
// read requests into card commands and status items.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   request   req_valid/req_stall   command, resp_high, resp_low, block_address
//   result    res_valid/res_stall   cmd_valid .. last (twelve fields)
//   config    cfg_we                cfg_index, cfg_data
//
// An accepted request is held in the input register, is resolved by the step
// logic and lands in a three-entry result queue. One request per cycle while
// each yields one result and the receiver does not stall; a start yields two
// results at once, which can fill the queue and stall the following request.
// Reset clears the sequencer and loads the register defaults.
// req_stall rises while the input register is full and two or more results
// are queued.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  command,
  input  logic [63:0] resp_high,
  input  logic [63:0] resp_low,
  input  logic [31:0] block_address,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        cmd_valid,
  output logic [5:0]  cmd_index,
  output logic [31:0] cmd_arg,
  output logic [1:0]  resp_kind,
  output logic        done_res,
  output logic [2:0]  error_code,
  output logic [15:0] card_rca,
  output logic [41:0] capacity_bytes,
  output logic [15:0] block_size,
  output logic [22:0] erase_sector_size,
  output logic        bus_wide,
  output logic        last
);
  import sdi_pkg::*;

  localparam logic [31:0] VOLTAGE_RST = 32'h8010_0000;
  localparam logic [11:0] PATTERN_RST = 12'h1AA;
  localparam logic [15:0] TRIALS_RST  = 16'hFFFF;

  logic [31:0] voltage_window;
  logic [11:0] check_pattern;
  logic [15:0] max_trials;

  push_t   push;
  logic    room;
  result_t head;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_window <= VOLTAGE_RST;
      check_pattern  <= PATTERN_RST;
      max_trials     <= TRIALS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLTAGE: voltage_window <= cfg_data;
        REG_PATTERN: check_pattern  <= cfg_data[11:0];
        REG_TRIALS:  max_trials     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  sdi_core u_core (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .command        (command),
    .resp_high      (resp_high),
    .resp_low       (resp_low),
    .block_address  (block_address),
    .voltage_window (voltage_window),
    .check_pattern  (check_pattern),
    .max_trials     (max_trials),
    .room           (room),
    .push           (push)
  );

  sdi_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign cmd_valid         = head.cmd_valid;
  assign cmd_index         = head.cmd_index;
  assign cmd_arg           = head.cmd_arg;
  assign resp_kind         = head.resp_kind;
  assign done_res          = head.done_res;
  assign error_code        = head.error_code;
  assign card_rca          = head.card_rca;
  assign capacity_bytes    = head.capacity_bytes;
  assign block_size        = head.block_size;
  assign erase_sector_size = head.erase_sector_size;
  assign bus_wide          = head.bus_wide;
  assign last              = head.last;

endmodule

/* rtl/sdi_core.sv */
// ----------------------------------------------------------------------------
// sdi_core
// Input register, sequencer state and the single-pass step logic. One held
// item per cycle, when the queue has room, becomes zero, one or two results.
// ----------------------------------------------------------------------------
module sdi_core (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  logic [1:0]     command,
  input  logic [63:0]    resp_high,
  input  logic [63:0]    resp_low,
  input  logic [31:0]    block_address,
  // configuration
  input  logic [31:0]    voltage_window,
  input  logic [11:0]    check_pattern,
  input  logic [15:0]    max_trials,
  // output queue
  input  logic           room,
  output sdi_pkg::push_t push
);
  import sdi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_W_CMD8   = 4'd1,
    PH_W_APP41  = 4'd2,
    PH_W_ACMD41 = 4'd3,
    PH_W_CID    = 4'd4,
    PH_W_RCA    = 4'd5,
    PH_W_CSD    = 4'd6,
    PH_W_SEL    = 4'd7,
    PH_W_APP6   = 4'd8,
    PH_W_ACMD6  = 4'd9,
    PH_READY    = 4'd10,
    PH_FAILED   = 4'd11,
    PH_R_SEL    = 4'd12,
    PH_R_DATA   = 4'd13
  } phase_t;

  localparam logic [31:0] HIGH_CAP_BIT = 32'h4000_0000;
  localparam logic [31:0] RCA_ERR_BITS = 32'h0000_2000 | 32'h0000_4000 | 32'h0000_8000;
  localparam logic [31:0] BUS_4BIT_ARG = 32'd2;
  localparam logic [1:0]  CSD_V2       = 2'b01;

  // held request
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [63:0] in_hi;
  logic [63:0] in_lo;
  logic [31:0] in_blk;

  // sequencer state
  phase_t      phase, phase_next;
  logic [15:0] trial_count, trial_count_next;
  logic [15:0] saved_rca, saved_rca_next;
  logic [41:0] saved_capacity, saved_capacity_next;
  logic [15:0] saved_block_size, saved_block_size_next;
  logic [22:0] saved_erase_size, saved_erase_size_next;
  logic [31:0] pending_block, pending_block_next;

  logic advance;
  logic accept;

  // first result descriptor
  logic [1:0]  n_res;
  logic        r_cmd;
  logic [5:0]  r_idx;
  logic [31:0] r_arg;
  logic [1:0]  r_kind;
  logic        r_done;
  logic [2:0]  r_err;

  // response decode
  logic [31:0] st;
  logic [31:0] rca_arg;
  logic [15:0] tc_inc;
  logic [21:0] c_size;
  logic [22:0] c_size_p1;
  logic [3:0]  rbl;
  logic [3:0]  wbl;
  logic [7:0]  sect_p1;
  logic        wide;

  assign advance   = in_full && room;
  assign req_stall = in_full && !room;
  assign accept    = req_valid && !req_stall;

  assign st        = in_hi[63:32];
  assign rca_arg   = {saved_rca, 16'h0000};
  assign tc_inc    = trial_count + 16'd1;
  assign c_size    = {in_hi[5:0], in_lo[63:48]};
  assign c_size_p1 = {1'b0, c_size} + 23'd1;
  assign rbl       = in_hi[19:16];
  assign wbl       = in_lo[25:22];
  assign sect_p1   = {1'b0, in_lo[45:39]} + 8'd1;

  // step logic: next state and first result
  always_comb begin
    phase_next            = phase;
    trial_count_next      = trial_count;
    saved_rca_next        = saved_rca;
    saved_capacity_next   = saved_capacity;
    saved_block_size_next = saved_block_size;
    saved_erase_size_next = saved_erase_size;
    pending_block_next    = pending_block;
    n_res  = 2'd0;
    r_cmd  = 1'b1;
    r_idx  = SD_CMD0;
    r_arg  = 32'd0;
    r_kind = RK_NONE;
    r_done = 1'b0;
    r_err  = ERR_OK;

    case (in_cmd)
      CMD_START: begin
        trial_count_next      = 16'd0;
        saved_rca_next        = 16'd0;
        saved_capacity_next   = 42'd0;
        saved_block_size_next = 16'd1;
        saved_erase_size_next = 23'd1;
        pending_block_next    = 32'd0;
        phase_next = PH_W_CMD8;
        n_res = 2'd2;
      end
      CMD_RESP: begin
        n_res = 2'd1;
        case (phase)
          PH_W_CMD8: begin
            if (st != {20'd0, check_pattern}) begin
              phase_next = PH_FAILED;
              r_cmd = 1'b0; r_done = 1'b1; r_err = ERR_PATTERN;
            end else begin
              phase_next = PH_W_APP41;
              r_idx = SD_CMD55; r_kind = RK_SHORT;
            end
          end
          PH_W_APP41: begin
            phase_next = PH_W_ACMD41;
            r_idx = SD_ACMD41; r_arg = voltage_window | HIGH_CAP_BIT; r_kind = RK_SHORT;
          end
          PH_W_ACMD41: begin
            if (st[31]) begin
              phase_next = PH_W_CID;
              r_idx = SD_CMD2; r_kind = RK_LONG;
            end else begin
              trial_count_next = tc_inc;
              if (tc_inc >= max_trials) begin
                phase_next = PH_FAILED;
                r_cmd = 1'b0; r_done = 1'b1; r_err = ERR_VOLTAGE;
              end else begin
                phase_next = PH_W_APP41;
                r_idx = SD_CMD55; r_kind = RK_SHORT;
              end
            end
          end
          PH_W_CID: begin
            phase_next = PH_W_RCA;
            r_idx = SD_CMD3; r_kind = RK_SHORT;
          end
          PH_W_RCA: begin
            if ((st & RCA_ERR_BITS) != 32'd0) begin
              phase_next = PH_FAILED;
              r_cmd = 1'b0; r_done = 1'b1; r_err = ERR_RCA;
            end else begin
              saved_rca_next = st[31:16];
              phase_next = PH_W_CSD;
              r_idx = SD_CMD9; r_arg = {st[31:16], 16'h0000}; r_kind = RK_LONG;
            end
          end
          PH_W_CSD: begin
            if (in_hi[63:62] != CSD_V2) begin
              phase_next = PH_FAILED;
              r_cmd = 1'b0; r_done = 1'b1; r_err = ERR_CSD;
            end else begin
              // capacity is 512 KiB units of C_SIZE plus one
              saved_capacity_next   = {c_size_p1, 19'd0};
              saved_block_size_next = 16'd1 << rbl;
              saved_erase_size_next = {15'd0, sect_p1} << wbl;
              phase_next = PH_W_SEL;
              r_idx = SD_CMD7; r_arg = rca_arg; r_kind = RK_SHORT;
            end
          end
          PH_W_SEL: begin
            phase_next = PH_W_APP6;
            r_idx = SD_CMD55; r_arg = rca_arg; r_kind = RK_SHORT;
          end
          PH_W_APP6: begin
            phase_next = PH_W_ACMD6;
            r_idx = SD_ACMD6; r_arg = BUS_4BIT_ARG; r_kind = RK_SHORT;
          end
          PH_W_ACMD6: begin
            phase_next = PH_READY;
            r_cmd = 1'b0; r_done = 1'b1;
          end
          PH_R_SEL: begin
            phase_next = PH_R_DATA;
            r_idx = SD_CMD17; r_arg = pending_block; r_kind = RK_SHORT;
          end
          PH_R_DATA: begin
            phase_next = PH_READY;
            n_res = 2'd0;
          end
          default: begin
            n_res = 2'd0;
          end
        endcase
      end
      CMD_TIMEOUT: begin
        r_cmd  = 1'b0;
        r_done = 1'b1;
        case (phase)
          PH_IDLE, PH_READY, PH_FAILED: begin
            n_res = 2'd0;
          end
          PH_W_CMD8: begin
            n_res = 2'd1; phase_next = PH_FAILED; r_err = ERR_V1;
          end
          PH_R_SEL, PH_R_DATA: begin
            n_res = 2'd1; phase_next = PH_READY; r_err = ERR_NORESP;
          end
          default: begin
            n_res = 2'd1; phase_next = PH_FAILED; r_err = ERR_NORESP;
          end
        endcase
      end
      CMD_READ: begin
        if (phase == PH_READY) begin
          pending_block_next = in_blk;
          phase_next = PH_R_SEL;
          n_res = 2'd1;
          r_idx = SD_CMD7; r_arg = rca_arg; r_kind = RK_SHORT;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  // result items carry the state as it stands after the step
  assign wide = phase_next inside {PH_READY, PH_R_SEL, PH_R_DATA};

  always_comb begin
    push.count                    = advance ? n_res : 2'd0;
    push.first.cmd_valid          = r_cmd;
    push.first.cmd_index          = r_idx;
    push.first.cmd_arg            = r_arg;
    push.first.resp_kind          = r_kind;
    push.first.done_res           = r_done;
    push.first.error_code         = r_err;
    push.first.card_rca           = saved_rca_next;
    push.first.capacity_bytes     = saved_capacity_next;
    push.first.block_size         = saved_block_size_next;
    push.first.erase_sector_size  = saved_erase_size_next;
    push.first.bus_wide           = wide;
    push.first.last               = (n_res == 2'd1);
    // second item only follows a start: CMD8 with the check pattern
    push.second                   = push.first;
    push.second.cmd_valid         = 1'b1;
    push.second.cmd_index         = SD_CMD8;
    push.second.cmd_arg           = {20'd0, check_pattern};
    push.second.resp_kind         = RK_SHORT;
    push.second.done_res          = 1'b0;
    push.second.error_code        = ERR_OK;
    push.second.last              = 1'b1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (accept) begin
      in_cmd <= command;
      in_hi  <= resp_high;
      in_lo  <= resp_low;
      in_blk <= block_address;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      trial_count      <= 16'd0;
      saved_rca        <= 16'd0;
      saved_capacity   <= 42'd0;
      saved_block_size <= 16'd1;
      saved_erase_size <= 23'd1;
      pending_block    <= 32'd0;
    end else if (advance) begin
      phase            <= phase_next;
      trial_count      <= trial_count_next;
      saved_rca        <= saved_rca_next;
      saved_capacity   <= saved_capacity_next;
      saved_block_size <= saved_block_size_next;
      saved_erase_size <= saved_erase_size_next;
      pending_block    <= pending_block_next;
    end
  end

endmodule

/* rtl/sdi_outq.sv */
// ----------------------------------------------------------------------------
// sdi_outq
// Three-entry result queue. Takes up to two items a cycle, presents the
// oldest on the result channel; head is always entry zero.
// ----------------------------------------------------------------------------
module sdi_outq (
  input  logic           clk,
  input  logic           rst,
  input  sdi_pkg::push_t push,
  output logic           room,
  output logic           res_valid,
  input  logic           res_stall,
  output sdi_pkg::result_t head
);
  import sdi_pkg::*;

  localparam int Depth = 3;

  result_t     q [Depth];
  result_t     q_next [Depth];
  logic [1:0]  cnt, cnt_next;
  logic [1:0]  base;
  logic        pop;

  assign res_valid = (cnt != 2'd0);
  assign pop       = res_valid && !res_stall;
  // space for a worst-case push of two
  assign room      = (cnt <= 2'd1);
  assign base      = cnt - {1'b0, pop};
  assign cnt_next  = base + push.count;
  assign head      = q[0];

  // shift on pop, then drop new items in behind the survivors
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if ((push.count != 2'd0) && (2'(i) == base)) begin
        q_next[i] = push.first;
      end
      if ((push.count == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_next[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    for (int i = 0; i < Depth; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SD card identification sequencer. A scripted
// opening walks the enumeration, read and error paths; random traffic then
// drives mostly well-formed card conversations under several register
// settings and idling patterns. Every result item is checked field by field
// against a cycle-free model of the sequencer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdi_pkg::*;

  localparam logic [31:0] HCS_BIT      = 32'h4000_0000;
  localparam logic [31:0] RCA_ERR_MASK = 32'h0000_E000;
  localparam logic [31:0] BUS_4BIT_ARG = 32'd2;
  localparam logic [1:0]  CSD_V2       = 2'b01;

  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 600000;

  typedef enum logic [3:0] {
    S_IDLE, S_W_CMD8, S_W_APP41, S_W_ACMD41, S_W_CID, S_W_RCA, S_W_CSD,
    S_W_SEL, S_W_APP6, S_W_ACMD6, S_READY, S_FAILED, S_R_SEL, S_R_DATA
  } seq_phase_t;

  // scripted item; want_n < 0 means the row is left to the model alone
  typedef struct {
    logic [1:0]  req;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] addr;
    int          want_n;
    logic [2:0]  want_err;
  } script_row_t;

  // DUT connections
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_VOLTAGE;
  logic [31:0] cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  command = CMD_START;
  logic [63:0] resp_high = '0;
  logic [63:0] resp_low = '0;
  logic [31:0] block_address = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        cmd_valid;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [1:0]  resp_kind;
  logic        done_res;
  logic [2:0]  error_code;
  logic [15:0] card_rca;
  logic [41:0] capacity_bytes;
  logic [15:0] block_size;
  logic [22:0] erase_sector_size;
  logic        bus_wide;
  logic        last;

  // register copies and sequencer state as the bench sees it
  logic [31:0] win_cfg     = 32'h8010_0000;
  logic [11:0] pattern_cfg = 12'h1AA;
  logic [15:0] trials_cfg  = 16'hFFFF;
  seq_phase_t  sq_phase    = S_IDLE;
  logic [15:0] try_count   = '0;
  logic [15:0] held_rca    = '0;
  logic [41:0] held_cap    = '0;
  logic [15:0] held_bsize  = 16'd1;
  logic [22:0] held_esize  = 23'd1;
  logic [31:0] read_block  = '0;

  result_t due_results[$];
  int      mismatches = 0;
  int      cycle_cnt = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_req = 1'b0;
  logic    hold_seen = 1'b0;
  int      hold_left = 0;

  script_row_t script [0:27] = '{
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, 0, ERR_OK},              // ignored while idle
    '{CMD_READ,    64'h0, 64'h0, 32'hFFFF_FFFF, 0, ERR_OK},      // read before ready
    '{CMD_START,   64'h0, 64'h0, 32'h0, 2, ERR_OK},
    '{CMD_TIMEOUT, 64'h0, 64'h0, 32'h0, 1, ERR_V1},              // silent CMD8: v1 card
    '{CMD_START,   64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0000_01AA_FFFF_FFFF, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h7FFF_FFFF_0000_0000, 64'h0, 32'h0, 1, ERR_VOLTAGE},
    '{CMD_START,   64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0000_01AA_0000_0000, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'hFFFF_1FFF_0000_0000, 64'h0, 32'h0, -1, ERR_OK},
    // largest CSD: full C_SIZE, 32 KiB blocks, widest erase sector
    '{CMD_RESP,    64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, 1, ERR_OK},              // bus switched, ready
    '{CMD_TIMEOUT, 64'h0, 64'h0, 32'h0, 0, ERR_OK},              // ignored while ready
    '{CMD_READ,    64'h0, 64'h0, 32'hFFFF_FFFF, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, 0, ERR_OK},              // data phase done
    '{CMD_READ,    64'h0, 64'h0, 32'h0, -1, ERR_OK},
    '{CMD_TIMEOUT, 64'h0, 64'h0, 32'h0, 1, ERR_NORESP},
    '{CMD_READ,    64'h0, 64'h0, 32'h0123_4567, -1, ERR_OK},
    '{CMD_START,   64'h0, 64'h0, 32'h0, 2, ERR_OK},              // restart mid-read
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, 1, ERR_PATTERN},
    '{CMD_RESP,    64'h0, 64'h0, 32'h0, 0, ERR_OK}               // ignored once failed
  };

  sd_card_init_sequencer uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .command(command),
    .resp_high(resp_high), .resp_low(resp_low), .block_address(block_address),
    .res_valid(res_valid), .res_stall(res_stall),
    .cmd_valid(cmd_valid), .cmd_index(cmd_index), .cmd_arg(cmd_arg),
    .resp_kind(resp_kind), .done_res(done_res), .error_code(error_code),
    .card_rca(card_rca), .capacity_bytes(capacity_bytes), .block_size(block_size),
    .erase_sector_size(erase_sector_size), .bus_wide(bus_wide), .last(last)
  );

  always #5 clk = ~clk;

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // result item built from the state as it stands after the step
  function automatic result_t form_item(bit is_cmd, logic [5:0] idx, logic [31:0] arg,
                                        logic [1:0] kind, bit done, logic [2:0] err);
    result_t r;
    r.cmd_valid         = is_cmd;
    r.cmd_index         = idx;
    r.cmd_arg           = arg;
    r.resp_kind         = kind;
    r.done_res          = done;
    r.error_code        = err;
    r.card_rca          = held_rca;
    r.capacity_bytes    = held_cap;
    r.block_size        = held_bsize;
    r.erase_sector_size = held_esize;
    r.bus_wide          = (sq_phase == S_READY || sq_phase == S_R_SEL ||
                           sq_phase == S_R_DATA);
    r.last              = 1'b0;
    return r;
  endfunction

  function automatic result_t status_item(logic [2:0] err);
    return form_item(1'b0, '0, '0, RK_NONE, 1'b1, err);
  endfunction

  function automatic result_t failed_item(logic [2:0] err);
    sq_phase = S_FAILED;
    return status_item(err);
  endfunction

  // one step of the sequencer: updates the state, queues what is due
  function automatic int advance_sequence(logic [1:0] req, logic [63:0] hi,
                                          logic [63:0] lo, logic [31:0] addr);
    result_t     outs [2];
    int          n;
    logic [31:0] st;
    logic [31:0] rca_arg;
    logic [21:0] c_size;
    logic [3:0]  rbl;
    logic [3:0]  wbl;
    logic [6:0]  sect;
    logic [31:0] esz;
    n = 0;
    st = hi[63:32];
    rca_arg = {held_rca, 16'h0};
    case (req)
      CMD_START: begin
        try_count  = '0;
        held_rca   = '0;
        held_cap   = '0;
        held_bsize = 16'd1;
        held_esize = 23'd1;
        read_block = '0;
        sq_phase   = S_W_CMD8;
        outs[0] = form_item(1'b1, SD_CMD0, '0, RK_NONE, 1'b0, ERR_OK);
        outs[1] = form_item(1'b1, SD_CMD8, {20'h0, pattern_cfg}, RK_SHORT,
                            1'b0, ERR_OK);
        n = 2;
      end
      CMD_RESP: begin
        n = 1;
        case (sq_phase)
          S_W_CMD8: begin
            // the whole status word must echo the pattern
            if (st != {20'h0, pattern_cfg}) begin
              outs[0] = failed_item(ERR_PATTERN);
            end else begin
              sq_phase = S_W_APP41;
              outs[0] = form_item(1'b1, SD_CMD55, '0, RK_SHORT, 1'b0, ERR_OK);
            end
          end
          S_W_APP41: begin
            sq_phase = S_W_ACMD41;
            outs[0] = form_item(1'b1, SD_ACMD41, win_cfg | HCS_BIT, RK_SHORT,
                                1'b0, ERR_OK);
          end
          S_W_ACMD41: begin
            if (st[31]) begin
              sq_phase = S_W_CID;
              outs[0] = form_item(1'b1, SD_CMD2, '0, RK_LONG, 1'b0, ERR_OK);
            end else begin
              try_count = try_count + 16'd1;
              if (try_count >= trials_cfg) begin
                outs[0] = failed_item(ERR_VOLTAGE);
              end else begin
                sq_phase = S_W_APP41;
                outs[0] = form_item(1'b1, SD_CMD55, '0, RK_SHORT, 1'b0, ERR_OK);
              end
            end
          end
          S_W_CID: begin
            sq_phase = S_W_RCA;
            outs[0] = form_item(1'b1, SD_CMD3, '0, RK_SHORT, 1'b0, ERR_OK);
          end
          S_W_RCA: begin
            if ((st & RCA_ERR_MASK) != 0) begin
              outs[0] = failed_item(ERR_RCA);
            end else begin
              held_rca = st[31:16];
              sq_phase = S_W_CSD;
              outs[0] = form_item(1'b1, SD_CMD9, {held_rca, 16'h0}, RK_LONG,
                                  1'b0, ERR_OK);
            end
          end
          S_W_CSD: begin
            if (hi[63:62] != CSD_V2) begin
              outs[0] = failed_item(ERR_CSD);
            end else begin
              c_size = {hi[5:0], lo[63:48]};
              rbl = hi[19:16];
              wbl = lo[25:22];
              sect = lo[45:39];
              held_cap = {{1'b0, c_size} + 23'd1, 19'd0};  // 512 KiB units
              held_bsize = 16'd1 << rbl;
              esz = (32'd1 << wbl) * ({25'd0, sect} + 32'd1);
              held_esize = esz[22:0];
              sq_phase = S_W_SEL;
              outs[0] = form_item(1'b1, SD_CMD7, rca_arg, RK_SHORT, 1'b0, ERR_OK);
            end
          end
          S_W_SEL: begin
            sq_phase = S_W_APP6;
            outs[0] = form_item(1'b1, SD_CMD55, rca_arg, RK_SHORT, 1'b0, ERR_OK);
          end
          S_W_APP6: begin
            sq_phase = S_W_ACMD6;
            outs[0] = form_item(1'b1, SD_ACMD6, BUS_4BIT_ARG, RK_SHORT,
                                1'b0, ERR_OK);
          end
          S_W_ACMD6: begin
            sq_phase = S_READY;
            outs[0] = status_item(ERR_OK);
          end
          S_R_SEL: begin
            sq_phase = S_R_DATA;
            outs[0] = form_item(1'b1, SD_CMD17, read_block, RK_SHORT, 1'b0,
                                ERR_OK);
          end
          S_R_DATA: begin
            sq_phase = S_READY;
            n = 0;
          end
          default: n = 0;
        endcase
      end
      CMD_TIMEOUT: begin
        n = 1;
        case (sq_phase)
          S_IDLE, S_READY, S_FAILED: n = 0;
          S_W_CMD8: outs[0] = failed_item(ERR_V1);
          S_R_SEL, S_R_DATA: begin
            sq_phase = S_READY;
            outs[0] = status_item(ERR_NORESP);
          end
          default: outs[0] = failed_item(ERR_NORESP);
        endcase
      end
      default: begin
        if (sq_phase == S_READY) begin
          read_block = addr;
          sq_phase = S_R_SEL;
          outs[0] = form_item(1'b1, SD_CMD7, rca_arg, RK_SHORT, 1'b0, ERR_OK);
          n = 1;
        end
      end
    endcase
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
    return n;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
    end
  endtask

  // offer one item after a random gap, predict once it is taken
  task automatic push_request(input logic [1:0] req, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [31:0] addr,
                              output int n);
    while (chance(send_idle_pct)) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid     <= 1'b1;
    command       <= req;
    resp_high     <= hi;
    resp_low      <= lo;
    block_address <= addr;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n = advance_sequence(req, hi, lo, addr);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_VOLTAGE: win_cfg = data;
      REG_PATTERN: pattern_cfg = data[11:0];
      REG_TRIALS:  trials_cfg = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for all due items, then let a dropped request clear the pipe
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(int sidle, int rstall, bit long_hold);
    @(negedge clk);
    send_idle_pct  <= sidle;
    recv_stall_pct <= rstall;
    if (long_hold) hold_req <= ~hold_req;
  endtask

  // mostly the answer a real card would give in the current phase
  task automatic run_random(int quota);
    int          served;
    int          n;
    logic [1:0]  req;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] addr;
    served = 0;
    while (served < quota) begin
      hi   = {$urandom, $urandom};
      lo   = {$urandom, $urandom};
      addr = $urandom;
      req  = CMD_RESP;
      if (chance(7)) begin
        req = 2'($urandom_range(3));
      end else begin
        case (sq_phase)
          S_IDLE, S_FAILED: req = CMD_START;
          S_W_CMD8: begin
            if (chance(8)) req = CMD_TIMEOUT;
            else if (chance(90)) hi[63:32] = {20'h0, pattern_cfg};
          end
          S_W_ACMD41: hi[63] = chance(50);
          S_W_RCA:    if (chance(88)) hi[47:45] = 3'b000;
          S_W_CSD:    if (chance(88)) hi[63:62] = CSD_V2;
          S_READY: begin
            if (chance(85)) req = CMD_READ;
            else req = chance(50) ? CMD_START : CMD_TIMEOUT;
          end
          S_R_SEL, S_R_DATA: if (chance(10)) req = CMD_TIMEOUT;
          default: if (chance(3)) req = CMD_TIMEOUT;
        endcase
      end
      push_request(req, hi, lo, addr, n);
      served++;
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= chance(recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      got = {cmd_valid, cmd_index, cmd_arg, resp_kind, done_res, error_code, card_rca,
             capacity_bytes, block_size, erase_sector_size, bus_wide, last};
      if (due_results.size() == 0) begin
        note_mismatch("item with nothing due, cmd_index", '0, 64'(got.cmd_index));
      end else begin
        want = due_results.pop_front();
        if (got.cmd_valid !== want.cmd_valid)
          note_mismatch("cmd_valid", 64'(want.cmd_valid), 64'(got.cmd_valid));
        if (got.cmd_index !== want.cmd_index)
          note_mismatch("cmd_index", 64'(want.cmd_index), 64'(got.cmd_index));
        if (got.cmd_arg !== want.cmd_arg)
          note_mismatch("cmd_arg", 64'(want.cmd_arg), 64'(got.cmd_arg));
        if (got.resp_kind !== want.resp_kind)
          note_mismatch("resp_kind", 64'(want.resp_kind), 64'(got.resp_kind));
        if (got.done_res !== want.done_res)
          note_mismatch("done_res", 64'(want.done_res), 64'(got.done_res));
        if (got.error_code !== want.error_code)
          note_mismatch("error_code", 64'(want.error_code), 64'(got.error_code));
        if (got.card_rca !== want.card_rca)
          note_mismatch("card_rca", 64'(want.card_rca), 64'(got.card_rca));
        if (got.capacity_bytes !== want.capacity_bytes)
          note_mismatch("capacity_bytes", 64'(want.capacity_bytes),
                        64'(got.capacity_bytes));
        if (got.block_size !== want.block_size)
          note_mismatch("block_size", 64'(want.block_size), 64'(got.block_size));
        if (got.erase_sector_size !== want.erase_sector_size)
          note_mismatch("erase_sector_size", 64'(want.erase_sector_size),
                        64'(got.erase_sector_size));
        if (got.bus_wide !== want.bus_wide)
          note_mismatch("bus_wide", 64'(want.bus_wide), 64'(got.bus_wide));
        if (got.last !== want.last)
          note_mismatch("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // scripted opening; a zero trial limit acts as one attempt
    write_reg(REG_TRIALS, 32'd0);
    foreach (script[i]) begin
      push_request(script[i].req, script[i].hi, script[i].lo, script[i].addr, n);
      if (script[i].want_n >= 0) begin
        if (n != script[i].want_n)
          note_mismatch($sformatf("row %0d item count", i), 64'(script[i].want_n),
                        64'(n));
        else if (n > 0 && due_results[$].error_code != script[i].want_err)
          note_mismatch($sformatf("row %0d error_code", i), 64'(script[i].want_err),
                        64'(due_results[$].error_code));
      end
    end
    settle();

    // all-ones window and pattern, single attempt; long receiver hold-off
    write_reg(REG_VOLTAGE, 32'hFFFF_FFFF);
    write_reg(REG_PATTERN, 32'h0000_0FFF);
    write_reg(REG_TRIALS, 32'd1);
    set_mode(0, 0, 1'b1);
    run_random(330);
    settle();

    // zero window and pattern, widest trial limit; sender gaps
    write_reg(REG_VOLTAGE, 32'h0);
    write_reg(REG_PATTERN, 32'h0);
    write_reg(REG_TRIALS, 32'h0000_FFFF);
    set_mode(53, 0, 1'b0);
    run_random(330);
    settle();

    // random values, junk above the narrow registers; receiver stalls
    write_reg(REG_VOLTAGE, $urandom);
    write_reg(REG_PATTERN, $urandom);
    write_reg(REG_TRIALS, {16'($urandom_range(65535)), 16'd3});
    set_mode(0, 53, 1'b0);
    run_random(330);
    settle();

    // back to the usual values, both sides idling
    write_reg(REG_VOLTAGE, 32'h8010_0000);
    write_reg(REG_PATTERN, 32'h0000_01AA);
    write_reg(REG_TRIALS, 32'd2);
    set_mode(22, 22, 1'b0);
    run_random(330);
    settle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
